@@ sv/lzeg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzeg_pkg: shared types for the LZ Elias-gamma decompressor
// Word formats of both channels and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lzeg_pkg;

	localparam int unsigned WIN_AW   = 15;   // history window address width
	localparam int unsigned CNT_W    = 9;    // run, copy and report counters
	localparam int unsigned GRP_N    = 4;    // bytes per output word
	localparam int unsigned GRP_CW   = 3;    // width of a group fill count
	localparam logic [CNT_W-1:0] EMIT_CAP  = 9'd256;
	localparam logic [CNT_W-1:0] EMIT_LAST = 9'd252;

	typedef struct packed {
		logic [7:0] compressed_byte;
		logic       start_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic [2:0] byte_count;
		logic       last_of_run;
		logic       stream_end;
	} out_word_t;

	typedef struct packed {
		logic clear;      // write one zero of the clearing pass
		logic accept;     // take the input word
		logic step;       // run one decode step
		logic rd;         // read one history byte of a match
		logic wr;         // write and report the byte read
		logic push_last;  // send the group, last of run
		logic push_grp;   // send the group, more to follow
		logic push_fin;   // send the group as last and end
		logic push_mark;  // send an empty end word
	} lzeg_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic fin_after;
		logic need;
		logic copy;
		logic ended;
		logic blocked;
		logic copy_last;
		logic grp_empty;
		logic cap_hi;
		logic out_free;
	} lzeg_stat_t;

endpackage

@@ sv/lzeg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzeg_ctrl: sequencing state machine
// Walks the clearing pass, input acceptance, decode steps, match copies and
// the output of the final groups of each input word.
// ----------------------------------------------------------------------------
module lzeg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lzeg_pkg::lzeg_stat_t st,
	output lzeg_pkg::lzeg_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_STEP  = 8'b0000_0100,
		S_RD    = 8'b0000_1000,
		S_WR    = 8'b0001_0000,
		S_DONE  = 8'b0010_0000,
		S_FIN   = 8'b0100_0000,
		S_MARK  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = st.fin_after ? S_IDLE : S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				priority if (st.blocked) state_d = S_STEP;
				else if (st.need) state_d = S_DONE;
				else if (st.ended) state_d = S_FIN;
				else if (st.copy) state_d = S_RD;
				else state_d = S_STEP;
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				cmd.wr = 1'b1;
				if (!st.blocked) state_d = st.copy_last ? S_STEP : S_RD;
			end
			S_DONE: begin
				priority if (st.grp_empty) state_d = S_IDLE;
				else if (st.out_free) begin
					cmd.push_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FIN: begin
				priority if (st.cap_hi) begin
					if (st.out_free) begin
						cmd.push_fin = 1'b1;
						state_d = S_IDLE;
					end
				end else if (st.grp_empty) state_d = S_MARK;
				else if (st.out_free) begin
					cmd.push_grp = 1'b1;
					state_d = S_MARK;
				end
			end
			S_MARK: begin
				if (st.out_free) begin
					cmd.push_mark = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

@@ sv/lzeg_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzeg_dp: decode datapath
// Bit reserve, Elias-gamma accumulator, offsets, history window memory,
// output grouping and the output register.
// ----------------------------------------------------------------------------
module lzeg_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lzeg_pkg::in_word_t   in_data,
	input  lzeg_pkg::lzeg_cmd_t  cmd,
	output lzeg_pkg::lzeg_stat_t st,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lzeg_pkg::out_word_t  out_data
);

	typedef enum logic [2:0] {
		PH_LIT_LEN   = 3'd0,
		PH_LIT_COPY  = 3'd1,
		PH_SEL_LIT   = 3'd2,
		PH_REP_LEN   = 3'd3,
		PH_OFF_MSB   = 3'd4,
		PH_OFF_LSB   = 3'd5,
		PH_NEW_LEN   = 3'd6,
		PH_SEL_MATCH = 3'd7
	} phase_t;

	localparam logic [7:0] RES_EMPTY = 8'h80;
	localparam int unsigned AW = lzeg_pkg::WIN_AW;
	localparam int unsigned CW = lzeg_pkg::CNT_W;

	logic [7:0] mem [2**AW];
	logic [7:0] rdata_q;

	phase_t          phase_q, phase_d;
	logic [7:0]      res_q, res_d;
	logic [1:0]      pend_q, pend_d;
	logic [AW-1:0]   loff_q, loff_d;
	logic [CW-1:0]   ev_q, ev_d;
	logic            eh_q, eh_d;
	logic [CW-1:0]   run_q, run_d;
	logic            fin_q, fin_d;
	logic            have_q, have_d;
	logic [7:0]      byte_q;
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   pos_q, pos_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [AW-1:0]   clr_q;
	logic [7:0]      grp_q [lzeg_pkg::GRP_N];
	logic [lzeg_pkg::GRP_CW-1:0] gcnt_q;
	logic [CW-1:0]   emitn_q;
	logic            ov_q;
	lzeg_pkg::out_word_t out_q;

	logic s_need, s_copy, s_end, lit_emit;
	logic got, bitv, c_done;
	logic [CW-1:0] c_v;
	logic [CW:0]   nv, len;

	// One decode step: fetch a control bit where the phase wants one and
	// advance the Elias-gamma code or the phase.
	always_comb begin
		phase_d = phase_q; res_d = res_q; pend_d = pend_q; loff_d = loff_q;
		ev_d = ev_q; eh_d = eh_q; run_d = run_q; fin_d = fin_q; have_d = have_q;
		pos_d = pos_q; cnt_d = cnt_q;
		s_need = 1'b0; s_copy = 1'b0; s_end = 1'b0; lit_emit = 1'b0;
		got = 1'b0; bitv = 1'b0; c_done = 1'b0; c_v = '0; nv = '0; len = '0;
		if (phase_q == PH_LIT_COPY) begin
			if (run_q == '0) phase_d = PH_SEL_LIT;
			else if (!have_q) s_need = 1'b1;
			else begin
				lit_emit = 1'b1;
				have_d = 1'b0;
				run_d = run_q - CW'(1);
			end
		end else if (phase_q == PH_OFF_LSB) begin
			if (!have_q) s_need = 1'b1;
			else begin
				have_d = 1'b0;
				pend_d = {1'b1, byte_q[0]};
				loff_d = {ev_q[7:0] - 8'd1, byte_q[7:1]};
				phase_d = PH_NEW_LEN;
				ev_d = CW'(1);
				eh_d = 1'b0;
			end
		end else begin
			priority if (pend_q[1]) begin
				got = 1'b1; bitv = pend_q[0]; pend_d = '0;
			end else if (res_q != RES_EMPTY) begin
				got = 1'b1; bitv = res_q[7]; res_d = {res_q[6:0], 1'b0};
			end else if (have_q) begin
				got = 1'b1; bitv = byte_q[7]; res_d = {byte_q[6:0], 1'b1};
				have_d = 1'b0;
			end else begin
				s_need = 1'b1;
			end
			if (got) begin
				if (phase_q == PH_SEL_LIT || phase_q == PH_SEL_MATCH) begin
					ev_d = CW'(1);
					eh_d = 1'b0;
					if (bitv) phase_d = PH_OFF_MSB;
					else phase_d = (phase_q == PH_SEL_LIT) ? PH_REP_LEN : PH_LIT_LEN;
				end else begin
					if (!eh_q) begin
						if (!bitv) begin
							c_done = 1'b1; c_v = ev_q;
						end else eh_d = 1'b1;
					end else begin
						nv = {ev_q, bitv};
						eh_d = 1'b0;
						if (nv > (CW+1)'(256)) begin
							ev_d = '0; c_done = 1'b1; c_v = '0;
						end else ev_d = nv[CW-1:0];
					end
					if (c_done) begin
						unique case (phase_q)
							PH_LIT_LEN: begin
								if (c_v == '0) phase_d = PH_SEL_LIT;
								else begin
									run_d = c_v;
									phase_d = PH_LIT_COPY;
								end
							end
							PH_OFF_MSB: begin
								if (c_v[7:0] == 8'd0) begin
									s_end = 1'b1;
									fin_d = 1'b1;
								end else begin
									ev_d = c_v;
									phase_d = PH_OFF_LSB;
								end
							end
							default: begin
								// Repeat or new-offset match length.
								len = {1'b0, c_v} + {{CW{1'b0}}, phase_q == PH_NEW_LEN};
								if (len > (CW+1)'(256)) len = {2'b00, len[7:0]};
								if (len != '0) s_copy = 1'b1;
								cnt_d = len[CW-1:0];
								pos_d = wp_q - loff_q - AW'(1);
								phase_d = PH_SEL_MATCH;
							end
						endcase
					end
				end
			end
		end
	end

	// Byte emission shared by literals and match copies.
	logic       em_req, em_push, blocked, em_fire, step_fire, out_free, cmd_push;
	logic [7:0] em_byte;

	assign out_free = !ov_q || out_ready;
	assign em_req   = (cmd.step && lit_emit) || cmd.wr;
	assign em_byte  = cmd.wr ? rdata_q : byte_q;
	assign em_push  = (emitn_q != lzeg_pkg::EMIT_CAP) && (gcnt_q == 3'd4);
	assign blocked  = em_req && em_push && !out_free;
	assign em_fire  = em_req && !blocked;
	assign step_fire = cmd.step && !blocked;
	assign cmd_push = cmd.push_last || cmd.push_grp || cmd.push_fin || cmd.push_mark;

	function automatic lzeg_pkg::out_word_t grp_word(input logic [7:0] b0,
		input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3,
		input logic [2:0] n, input logic last, input logic fin);
		lzeg_pkg::out_word_t w;
		w.out_byte0   = (n > 3'd0) ? b0 : 8'd0;
		w.out_byte1   = (n > 3'd1) ? b1 : 8'd0;
		w.out_byte2   = (n > 3'd2) ? b2 : 8'd0;
		w.out_byte3   = (n > 3'd3) ? b3 : 8'd0;
		w.byte_count  = n;
		w.last_of_run = last;
		w.stream_end  = fin;
		return w;
	endfunction

	// History window with the clearing pass after reset.
	always_ff @(posedge clk) begin
		if (cmd.clear) mem[clr_q] <= 8'd0;
		else if (em_fire) mem[wp_q] <= em_byte;
		if (cmd.rd) rdata_q <= mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) byte_q <= in_data.compressed_byte;
		if (em_fire && (emitn_q != lzeg_pkg::EMIT_CAP)) begin
			if (em_push) grp_q[0] <= em_byte;
			else grp_q[gcnt_q[1:0]] <= em_byte;
		end
		if (em_fire && em_push) begin
			out_q <= grp_word(grp_q[0], grp_q[1], grp_q[2], grp_q[3], gcnt_q,
				1'b0, 1'b0);
		end else if (cmd.push_mark) begin
			out_q <= grp_word(8'd0, 8'd0, 8'd0, 8'd0, 3'd0, 1'b1, 1'b1);
		end else if (cmd_push) begin
			out_q <= grp_word(grp_q[0], grp_q[1], grp_q[2], grp_q[3], gcnt_q,
				!cmd.push_grp, cmd.push_fin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LIT_LEN; res_q <= RES_EMPTY; pend_q <= '0; loff_q <= '0;
			ev_q <= CW'(1); eh_q <= 1'b0; run_q <= '0; wp_q <= '0; fin_q <= 1'b0;
			have_q <= 1'b0; pos_q <= '0; cnt_q <= '0; clr_q <= '0;
			gcnt_q <= '0; emitn_q <= '0; ov_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + AW'(1);
			if (cmd.accept) begin
				have_q <= 1'b1;
				emitn_q <= '0;
				if (in_data.start_of_stream) begin
					phase_q <= PH_LIT_LEN; res_q <= RES_EMPTY; pend_q <= '0;
					loff_q <= '0; ev_q <= CW'(1); eh_q <= 1'b0; run_q <= '0;
					wp_q <= '0; fin_q <= 1'b0;
				end
			end else if (step_fire) begin
				phase_q <= phase_d; res_q <= res_d; pend_q <= pend_d;
				loff_q <= loff_d; ev_q <= ev_d; eh_q <= eh_d; run_q <= run_d;
				fin_q <= fin_d; have_q <= have_d; pos_q <= pos_d; cnt_q <= cnt_d;
			end else if (cmd.wr && em_fire) begin
				pos_q <= pos_q + AW'(1);
				cnt_q <= cnt_q - CW'(1);
			end
			if (em_fire) begin
				wp_q <= wp_q + AW'(1);
				if (emitn_q != lzeg_pkg::EMIT_CAP) begin
					emitn_q <= emitn_q + CW'(1);
					gcnt_q <= em_push ? 3'd1 : gcnt_q + 3'd1;
				end
			end else if (cmd_push) gcnt_q <= '0;
			if ((em_fire && em_push) || cmd_push) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign st.clear_done = (clr_q == '1);
	assign st.fin_after  = fin_q && !in_data.start_of_stream;
	assign st.need       = s_need;
	assign st.copy       = s_copy;
	assign st.ended      = s_end;
	assign st.blocked    = blocked;
	assign st.copy_last  = (cnt_q == CW'(1));
	assign st.grp_empty  = (gcnt_q == '0);
	assign st.cap_hi     = (emitn_q > lzeg_pkg::EMIT_LAST);
	assign st.out_free   = out_free;

	assign out_valid = ov_q;
	assign out_data  = out_q;

endmodule

@@ sv/lz_elias_gamma_decompressor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_elias_gamma_decompressor: streaming LZ decoder with Elias-gamma codes
// Decodes literal runs, new-offset and repeat-offset matches from a byte
// stream and reports the decoded bytes in words of up to four.
// ----------------------------------------------------------------------------
//
//   channel  | handshake             | word
//   ---------+-----------------------+------------------------------------
//   input    | in_valid / in_ready   | in_data  (compressed byte, restart)
//   output   | out_valid / out_ready | out_data (4 bytes, count, flags)
//
// After reset the block clears the history window and takes no input word
// during that pass.
// Each input word takes an accept step, a decode step for about each control
// bit or literal byte, a history read and a write per match byte, and the
// sending of up to two final words.
// The output register lets the decoder keep working while a word waits; the
// decoder stalls whenever a full group or a final word must leave while the
// register still holds a word that has not been taken.
// Reset is asynchronous and active low; start_of_stream restarts decoding
// but keeps the window contents.
module lz_elias_gamma_decompressor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lzeg_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lzeg_pkg::out_word_t out_data
);

	lzeg_pkg::lzeg_cmd_t  cmd;
	lzeg_pkg::lzeg_stat_t st;

	// The controller sequences the work; the datapath holds all decoder state.
	lzeg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	lzeg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ dv/tb_lz_elias_gamma_decompressor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz_elias_gamma_decompressor: self-checking bench for the LZ decoder
// Feeds directed and random compressed streams with random idling on both
// channels and checks every output word against a behavioral decoder.
// ----------------------------------------------------------------------------

// Behavioral decoder plus the queue of output words it predicts.
class lzeg_scoreboard;

	// Decode phases of the stream format.
	typedef enum logic [2:0] {
		LIT_LEN, LIT_COPY, SEL_LIT, REP_LEN, OFF_MSB, OFF_LSB, NEW_LEN, SEL_MATCH
	} phase_e;

	localparam int WIN = 32768;

	phase_e     phase;
	logic [7:0] reserve;
	logic [1:0] spare_bit;
	logic [14:0] prev_offset;
	int         gamma;
	bit         gamma_half;
	int         lit_left;
	int         wr_ptr;
	logic [7:0] window [WIN];
	bit         done;

	lzeg_pkg::out_word_t expected_words [$];
	logic [7:0] decoded [$];
	int errors;
	int words_in;
	int words_out;
	int ends_seen;
	int restarts;

	function void restart();
		phase = LIT_LEN;
		reserve = 8'h80;
		spare_bit = 2'd0;
		prev_offset = '0;
		gamma = 1;
		gamma_half = 0;
		lit_left = 0;
		wr_ptr = 0;
		done = 0;
	endfunction

	function new();
		for (int i = 0; i < WIN; i++) window[i] = 8'h00;
		restart();
		errors = 0;
		words_in = 0;
		words_out = 0;
		ends_seen = 0;
		restarts = 0;
	endfunction

	function void store_byte(logic [7:0] b);
		window[wr_ptr] = b;
		wr_ptr = (wr_ptr + 1) % WIN;
		decoded.push_back(b);
	endfunction

	function void open_code(phase_e p);
		phase = p;
		gamma = 1;
		gamma_half = 0;
	endfunction

	// Next control bit: pending offset bit first, then the reserve, then a
	// fresh byte. Returns -1 when a fresh byte is needed and already used.
	function int next_bit(ref bit have, input logic [7:0] b);
		int r;
		if (spare_bit != 2'd0) begin
			r = spare_bit[0];
			spare_bit = 2'd0;
		end else if (reserve != 8'h80) begin
			r = reserve[7];
			reserve = reserve << 1;
		end else if (have) begin
			r = b[7];
			reserve = {b[6:0], 1'b1};
			have = 0;
		end else begin
			r = -1;
		end
		return r;
	endfunction

	// Interlaced Elias-gamma: continuation bit, then data bit.
	function int gamma_feed(int bt);
		if (!gamma_half) begin
			if (bt == 0) return gamma;
			gamma_half = 1;
			return -1;
		end
		gamma = (gamma << 1) | bt;
		gamma_half = 0;
		if (gamma > 256) begin
			gamma = 0;
			return 0;
		end
		return -1;
	endfunction

	function void copy_from_window(int len);
		int pos;
		pos = (wr_ptr + 2 * WIN - int'(prev_offset) - 1) % WIN;
		for (int i = 0; i < len; i++) begin
			store_byte(window[pos]);
			pos = (pos + 1) % WIN;
		end
	endfunction

	// Called for each accepted input word.
	function void note_input(lzeg_pkg::in_word_t w);
		bit have;
		bit ended;
		int bt;
		int v;
		int len;
		int ngrp;
		lzeg_pkg::out_word_t o;
		logic [7:0] g [4];

		words_in++;
		decoded.delete();
		have = 1;
		ended = 0;
		if (w.start_of_stream) begin
			restart();
			restarts++;
		end
		if (done) return;

		while (1) begin
			if (phase == LIT_COPY) begin
				if (lit_left == 0) begin
					phase = SEL_LIT;
					continue;
				end
				if (!have) break;
				have = 0;
				store_byte(w.compressed_byte);
				lit_left--;
				continue;
			end
			if (phase == OFF_LSB) begin
				if (!have) break;
				have = 0;
				spare_bit = {1'b1, w.compressed_byte[0]};
				prev_offset = 15'(((gamma - 1) << 7) | (w.compressed_byte >> 1));
				open_code(NEW_LEN);
				continue;
			end
			bt = next_bit(have, w.compressed_byte);
			if (bt < 0) break;
			case (phase)
				LIT_LEN: begin
					v = gamma_feed(bt);
					if (v == 0) phase = SEL_LIT;
					else if (v > 0) begin
						lit_left = v;
						phase = LIT_COPY;
					end
				end
				SEL_LIT: open_code(bt ? OFF_MSB : REP_LEN);
				SEL_MATCH: open_code(bt ? OFF_MSB : LIT_LEN);
				REP_LEN, NEW_LEN: begin
					v = gamma_feed(bt);
					if (v >= 0) begin
						len = v + ((phase == NEW_LEN) ? 1 : 0);
						if (len > 256) len = len & 8'hFF;
						copy_from_window(len);
						phase = SEL_MATCH;
					end
				end
				default: begin
					v = gamma_feed(bt);
					if (v >= 0) begin
						if ((v & 8'hFF) == 0) begin
							done = 1;
							ended = 1;
						end else begin
							gamma = v;
							phase = OFF_LSB;
						end
					end
				end
			endcase
			if (ended) break;
		end

		// Pack the decoded bytes into words of four.
		ngrp = (decoded.size() + 3) / 4;
		for (int k = 0; k < ngrp; k++) begin
			for (int j = 0; j < 4; j++)
				g[j] = (k * 4 + j < decoded.size()) ? decoded[k * 4 + j] : 8'h00;
			o = '0;
			o.out_byte0 = g[0];
			o.out_byte1 = g[1];
			o.out_byte2 = g[2];
			o.out_byte3 = g[3];
			o.byte_count = 3'((decoded.size() - k * 4 > 4) ? 4 : decoded.size() - k * 4);
			o.last_of_run = (k == ngrp - 1) && !ended;
			o.stream_end = 0;
			expected_words.push_back(o);
		end
		if (ended) begin
			o = '0;
			o.last_of_run = 1;
			o.stream_end = 1;
			expected_words.push_back(o);
			ends_seen++;
		end
	endfunction

	function void report_field(string name, logic [7:0] exp, logic [7:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, got);
		errors++;
	endfunction

	// Called for each accepted output word.
	function void check_output(lzeg_pkg::out_word_t got);
		lzeg_pkg::out_word_t exp;
		words_out++;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected output word %h", $time, got);
			errors++;
			return;
		end
		exp = expected_words.pop_front();
		if (got.out_byte0 !== exp.out_byte0)
			report_field("out_byte0", exp.out_byte0, got.out_byte0);
		if (got.out_byte1 !== exp.out_byte1)
			report_field("out_byte1", exp.out_byte1, got.out_byte1);
		if (got.out_byte2 !== exp.out_byte2)
			report_field("out_byte2", exp.out_byte2, got.out_byte2);
		if (got.out_byte3 !== exp.out_byte3)
			report_field("out_byte3", exp.out_byte3, got.out_byte3);
		if (got.byte_count !== exp.byte_count)
			report_field("byte_count", exp.byte_count, got.byte_count);
		if (got.last_of_run !== exp.last_of_run)
			report_field("last_of_run", exp.last_of_run, got.last_of_run);
		if (got.stream_end !== exp.stream_end)
			report_field("stream_end", exp.stream_end, got.stream_end);
	endfunction

endclass

module tb_lz_elias_gamma_decompressor;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	lzeg_pkg::in_word_t  in_data;
	logic                out_valid;
	logic                out_ready;
	lzeg_pkg::out_word_t out_data;

	lzeg_scoreboard decode_sb;

	// Receiver controls: quiet turns off idling near the end, long_hold asks
	// the receiver for one long back-pressure stretch.
	bit quiet;
	bit long_hold;

	lz_elias_gamma_decompressor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Both channels are observed at the rising edge, where the inputs have
	// been stable since the previous falling edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) decode_sb.note_input(in_data);
		if (arst_n && out_valid && out_ready) decode_sb.check_output(out_data);
	end

	// Offer one word and hold it until the block takes it. Returns at the
	// falling edge after acceptance, so the caller may drive the next word.
	task automatic send_word(logic [7:0] b, logic sos);
		lzeg_pkg::in_word_t w;
		w.compressed_byte = b;
		w.start_of_stream = sos;
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Random sender gap, taken about one time in four.
	task automatic maybe_gap();
		int n;
		if (!quiet && $urandom_range(3) == 0) begin
			n = $urandom_range(9, 1);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Receiver: ready toggles in random bursts; one long hold on request.
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
				long_hold = 0;
			end else if (!quiet && $urandom_range(3) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(9, 1);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				n = $urandom_range(9, 1);
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [7:0] directed [] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h01,
			8'h7F, 8'hFE, 8'h40, 8'h12, 8'hC3, 8'h3C, 8'h00, 8'hFF};
		int waited;
		bit sos;

		decode_sb = new();
		quiet = 0;
		long_hold = 0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extreme bytes, restarts mid-stream, a few streams that
		// hit the end marker (all-ones codes read as zero) and bytes fed
		// after the end, which the decoder must ignore.
		foreach (directed[i]) begin
			send_word(directed[i], i == 0 || i == 9);
			maybe_gap();
		end
		send_word(8'hFF, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h5A, 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'hAB, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);

		// Random streams. Restarts are occasional, and mostly follow an end
		// so that few words land on a finished decoder.
		for (int i = 0; i < 150; i++) begin
			if (i == 40) long_hold = 1;
			if (i == 120) quiet = 1;
			if (decode_sb.done) sos = ($urandom_range(4) != 0);
			else sos = ($urandom_range(24) == 0);
			send_word(8'($urandom_range(255)), sos);
			maybe_gap();
		end
		in_valid <= 1'b0;

		waited = 0;
		while (decode_sb.expected_words.size() != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (1200) @(negedge clk);

		if (decode_sb.expected_words.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time,
				decode_sb.expected_words.size());
			decode_sb.errors++;
		end
		$display("Sent %0d compressed words with %0d restarts; checked %0d output words",
			decode_sb.words_in, decode_sb.restarts, decode_sb.words_out);
		$display("End markers decoded: %0d, mismatches: %0d",
			decode_sb.ends_seen, decode_sb.errors);
		if (decode_sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: covers the clearing pass, long copies and heavy stalls.
	initial begin
		#4000000;
		$display("Timeout at %0t", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
